### hdl/color_dominance_blob_detector_defines.svh
// Assertion macros shared by the blob detector's checking code.
// No dependencies; include guard keeps it single-shot.
`ifndef COLOR_DOMINANCE_BLOB_DETECTOR_DEFINES_SVH
`define COLOR_DOMINANCE_BLOB_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blob detector check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blob detector check failed");

`endif

### hdl/cdbd_pkg.sv
// Shared types and constants of the blob detector.
// Used by cdbd_ctrl, cdbd_datapath and the top level; no dependencies.
package cdbd_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GREEN_FLOOR  = 3'd2;
  localparam logic [2:0] REG_MARGIN       = 3'd3;
  localparam logic [2:0] REG_DETECT_RATIO = 3'd4;
  localparam logic [2:0] REG_CLOSE_RATIO  = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [20:0] TALLY_MAX = 21'h1FFFFF;
  localparam logic [29:0] SUM_MAX   = 30'h3FFFFFFF;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  // Both quotients are 16 bits wide, one bit per division step.
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;   // a pixel word is taken this cycle
    logic capture;  // that word closes the frame
    logic start;    // load products and remainders
    logic step;     // one restoring division step
    logic finish;   // form the result word
  } cmd_t;

endpackage

### hdl/cdbd_ctrl.sv
// Sequencer of the blob detector: handshakes and division step count.
// Depends on cdbd_pkg.
module cdbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_frame_end,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output cdbd_pkg::cmd_t  cmd
);

  cdbd_pkg::state_t                    state_r, state_nxt;
  logic [cdbd_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                                accept;
  logic                                capture;

  assign in_ready  = (state_r == cdbd_pkg::ST_IDLE) ||
                     ((state_r == cdbd_pkg::ST_OUT) && out_ready);
  assign out_valid = (state_r == cdbd_pkg::ST_OUT);
  assign accept    = in_valid && in_ready;
  assign capture   = accept && in_frame_end;

  assign cmd.accept  = accept;
  assign cmd.capture = capture;
  assign cmd.start   = (state_r == cdbd_pkg::ST_MUL);
  assign cmd.step    = (state_r == cdbd_pkg::ST_DIV);
  assign cmd.finish  = (state_r == cdbd_pkg::ST_FIN);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      cdbd_pkg::ST_IDLE: begin
        if (capture) state_nxt = cdbd_pkg::ST_MUL;
      end
      cdbd_pkg::ST_MUL: begin
        state_nxt = cdbd_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      cdbd_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == cdbd_pkg::DIV_CNT_W'(cdbd_pkg::DIV_STEPS - 1)) begin
          state_nxt = cdbd_pkg::ST_FIN;
        end
      end
      cdbd_pkg::ST_FIN: begin
        state_nxt = cdbd_pkg::ST_OUT;
      end
      cdbd_pkg::ST_OUT: begin
        if (out_ready) state_nxt = capture ? cdbd_pkg::ST_MUL : cdbd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cdbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdbd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hdl/cdbd_datapath.sv
// Datapath of the blob detector: registers, accumulators, products,
// two restoring dividers and the result word. Depends on cdbd_pkg.
module cdbd_datapath #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cdbd_pkg::cmd_t                    cmd,
  input  logic                              cfg_we,
  input  logic [cdbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                        in_red_level,
  input  logic [7:0]                        in_green_level,
  input  logic [7:0]                        in_blue_level,
  input  logic [9:0]                        in_column,
  output logic [20:0]                       out_green_pixels,
  output logic [16:0]                       out_ratio_q16,
  output logic                              out_detected,
  output logic                              out_close_by,
  output logic signed [15:0]                out_center_q15
);

  // Configuration registers.
  logic [10:0] width_r, height_r;
  logic [7:0]  floor_r, margin_r;
  logic [16:0] detect_r, close_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd64;
      height_r <= 11'd64;
      floor_r  <= 8'd100;
      margin_r <= 8'd30;
      detect_r <= 17'd655;
      close_r  <= 17'd9830;
    end else if (cfg_we) begin
      case (cfg_index)
        cdbd_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data[10:0];
        cdbd_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data[10:0];
        cdbd_pkg::REG_GREEN_FLOOR:  floor_r  <= cfg_data[7:0];
        cdbd_pkg::REG_MARGIN:       margin_r <= cfg_data[7:0];
        cdbd_pkg::REG_DETECT_RATIO: detect_r <= cfg_data;
        cdbd_pkg::REG_CLOSE_RATIO:  close_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped frame dimensions.
  logic [10:0] w_clamp, h_clamp;
  always_comb begin
    w_clamp = width_r;
    if (width_r == 11'd0) w_clamp = 11'd1;
    else if (32'(width_r) > MAX_COLS) w_clamp = 11'(MAX_COLS);
    h_clamp = height_r;
    if (height_r == 11'd0) h_clamp = 11'd1;
    else if (32'(height_r) > MAX_ROWS) h_clamp = 11'(MAX_ROWS);
  end

  // Pixel classification and saturating accumulation.
  logic        is_green;
  logic [20:0] tally_r, tally_upd;
  logic [29:0] sum_r, sum_upd;
  logic [30:0] sum_wide;
  logic [20:0] cnt_snap_r;
  logic [29:0] sum_snap_r;

  assign is_green = (in_green_level > floor_r) &&
                    ({1'b0, in_green_level} > ({1'b0, in_red_level} + {1'b0, margin_r})) &&
                    ({1'b0, in_green_level} > ({1'b0, in_blue_level} + {1'b0, margin_r}));
  assign sum_wide = {1'b0, sum_r} + {21'd0, in_column};

  always_comb begin
    tally_upd = tally_r;
    sum_upd   = sum_r;
    if (is_green) begin
      if (tally_r != cdbd_pkg::TALLY_MAX) tally_upd = tally_r + 1'b1;
      sum_upd = (sum_wide > {1'b0, cdbd_pkg::SUM_MAX}) ? cdbd_pkg::SUM_MAX : sum_wide[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      sum_r   <= '0;
    end else if (cmd.capture) begin
      tally_r <= '0;
      sum_r   <= '0;
    end else if (cmd.accept) begin
      tally_r <= tally_upd;
      sum_r   <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_snap_r <= tally_upd;
      sum_snap_r <= sum_upd;
    end
  end

  // Divisors and dividers. Quotient A is count/total, B is sum/(count*width),
  // both as 16-bit fractions; the overflow cases are decided at the end.
  logic [21:0] total_r;
  logic [31:0] dsor_r;
  logic [21:0] rem_a_r;
  logic [31:0] rem_b_r;
  logic [15:0] q_a_r, q_b_r;
  logic [22:0] rem_a_sh;
  logic [32:0] rem_b_sh;
  logic        bit_a, bit_b;

  assign rem_a_sh = {rem_a_r, 1'b0};
  assign rem_b_sh = {rem_b_r, 1'b0};
  assign bit_a    = (rem_a_sh >= {1'b0, total_r});
  assign bit_b    = (rem_b_sh >= {1'b0, dsor_r});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      total_r <= 22'(w_clamp * h_clamp);
      dsor_r  <= 32'(cnt_snap_r * w_clamp);
      rem_a_r <= {1'b0, cnt_snap_r};
      rem_b_r <= {2'b00, sum_snap_r};
      q_a_r   <= '0;
      q_b_r   <= '0;
    end else if (cmd.step) begin
      rem_a_r <= bit_a ? 22'(rem_a_sh - {1'b0, total_r}) : rem_a_sh[21:0];
      rem_b_r <= bit_b ? 32'(rem_b_sh - {1'b0, dsor_r}) : rem_b_sh[31:0];
      q_a_r   <= {q_a_r[14:0], bit_a};
      q_b_r   <= {q_b_r[14:0], bit_b};
    end
  end

  // Result word.
  logic [16:0] ratio;
  logic [15:0] qc;
  assign ratio = ({1'b0, cnt_snap_r} >= total_r) ? cdbd_pkg::ONE_Q16 : {1'b0, q_a_r};
  assign qc    = ({2'b00, sum_snap_r} >= dsor_r) ? 16'hFFFF : q_b_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_green_pixels <= cnt_snap_r;
      out_ratio_q16    <= ratio;
      out_detected     <= (ratio >= detect_r);
      out_close_by     <= (ratio >= close_r);
      out_center_q15   <= (cnt_snap_r == 21'd0) ? 16'sd0 : signed'({~qc[15], qc[14:0]});
    end
  end

endmodule

### hdl/color_dominance_blob_detector.sv
// Green-dominance blob detector: top level joining cdbd_ctrl and cdbd_datapath.
// Ordinary pixel words are taken one per cycle unless a frame result is being formed
// or waits to be taken. A word marked frame_end starts the frame's result: the products,
// sixteen restoring division steps (one quotient bit each) and the forming of the word,
// which is then offered; no pixel is taken meanwhile.
// Reset (synchronous, active low) restores register defaults and clears tallies.
`include "color_dominance_blob_detector_defines.svh"

module color_dominance_blob_detector #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Pixel channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_red_level,
  input  logic [7:0]                        in_green_level,
  input  logic [7:0]                        in_blue_level,
  input  logic [9:0]                        in_column,
  input  logic                              in_frame_end,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [20:0]                       out_green_pixels,
  output logic [16:0]                       out_ratio_q16,
  output logic                              out_detected,
  output logic                              out_close_by,
  output logic signed [15:0]                out_center_q15,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [cdbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The sequencer issues one command per cycle; the datapath only obeys.
  cdbd_pkg::cmd_t cmd;

  // While a result word waits, a new pixel word is taken only in the cycle the
  // result is taken too, so the held snapshot may be overwritten safely.
  cdbd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .out_ready    (out_ready),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  // The accumulators are cleared in the same cycle that the closing pixel's
  // totals are copied to the snapshot, so they are ready for the next frame at once.
  cdbd_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .in_column        (in_column),
    .out_green_pixels (out_green_pixels),
    .out_ratio_q16    (out_ratio_q16),
    .out_detected     (out_detected),
    .out_close_by     (out_close_by),
    .out_center_q15   (out_center_q15)
  );

  // A pixel is taken alongside a pending result only when that result leaves.
  `CDBD_ASSERT_NOW(a_take_with_result, clk, rst_n, in_ready && out_valid, out_ready)
  // A frame-closing pixel makes the block busy in the following cycle.
  `CDBD_ASSERT_NEXT(a_busy_after_end, clk, rst_n, in_valid && in_ready && in_frame_end, !in_ready)
  // An empty frame gives a zero ratio and a zero centre.
  `CDBD_ASSERT_NOW(a_empty_frame, clk, rst_n, out_valid && (out_green_pixels == 21'd0),
                   (out_ratio_q16 == 17'd0) && (out_center_q15 == 16'sd0))
  // The ratio never exceeds one in Q1.16.
  `CDBD_ASSERT_NOW(a_ratio_range, clk, rst_n, out_valid, out_ratio_q16 <= 17'h10000)

endmodule

### verif/tb_color_dominance_blob_detector.sv
`timescale 1ns / 1ps
// Testbench of color_dominance_blob_detector: directed and random pixel streams, every
// frame result checked word by word against an in-bench predictor of the frame statistics.
// Depends on cdbd_pkg (register indexes, saturation constants) and the RTL under hdl/.

module tb_color_dominance_blob_detector;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int HALF_PERIOD = 5;
  // Settling wait after the last due result, derived from the result latency.
  localparam int RESULT_LATENCY = 18;
  localparam int SETTLE_CYCLES = 2 * RESULT_LATENCY + 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_LIMIT_NS = 8_000_000;
  // Indexes past the last register: writes to them must change nothing.
  localparam logic [cdbd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [cdbd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] column;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [20:0] green_pixels;
    logic [16:0] ratio;
    logic        detected;
    logic        close_by;
    logic [15:0] centre;
  } blob_result_t;

  // Every input of the block starts at a known value.
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_red_level = '0;
  logic [7:0]                      in_green_level = '0;
  logic [7:0]                      in_blue_level = '0;
  logic [9:0]                      in_column = '0;
  logic                            in_frame_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [20:0]                     out_green_pixels;
  logic [16:0]                     out_ratio_q16;
  logic                            out_detected;
  logic                            out_close_by;
  logic signed [15:0]              out_center_q15;
  logic                            cfg_we = 1'b0;
  logic [cdbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cdbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor's own copy of the registers and of the running frame tallies.
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [7:0]  floor_reg;
  logic [7:0]  margin_reg;
  logic [16:0] detect_thr;
  logic [16:0] close_thr;
  logic [20:0] count_acc;
  logic [29:0] col_acc;

  // Frame results predicted but not yet seen on the result channel, oldest first.
  blob_result_t frame_results_due[$];
  blob_result_t due_word;

  int  mismatches = 0;
  int  pixels_sent = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  bit  idle_enable = 1'b1;
  // The test side bumps hold_requests; the receiver notices the change and holds off.
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  burst_left = 0;

  color_dominance_blob_detector #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red_level     (in_red_level),
    .in_green_level   (in_green_level),
    .in_blue_level    (in_blue_level),
    .in_column        (in_column),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_green_pixels (out_green_pixels),
    .out_ratio_q16    (out_ratio_q16),
    .out_detected     (out_detected),
    .out_close_by     (out_close_by),
    .out_center_q15   (out_center_q15),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // A frame dimension of zero counts as one, and anything past the maximum as the maximum.
  function automatic longint unsigned bound_dim(logic [10:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void reset_predictor();
    width_reg = 11'd64;
    height_reg = 11'd64;
    floor_reg = 8'd100;
    margin_reg = 8'd30;
    detect_thr = 17'd655;
    close_thr = 17'd9830;
    count_acc = '0;
    col_acc = '0;
  endfunction

  // Only the low bits of the data that fit the register are kept.
  function automatic void apply_reg(logic [cdbd_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cdbd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cdbd_pkg::REG_FRAME_WIDTH:  width_reg = data[10:0];
      cdbd_pkg::REG_FRAME_HEIGHT: height_reg = data[10:0];
      cdbd_pkg::REG_GREEN_FLOOR:  floor_reg = data[7:0];
      cdbd_pkg::REG_MARGIN:       margin_reg = data[7:0];
      cdbd_pkg::REG_DETECT_RATIO: detect_thr = data[16:0];
      cdbd_pkg::REG_CLOSE_RATIO:  close_thr = data[16:0];
      default: ;
    endcase
  endfunction

  // Folds one accepted pixel word into the tallies; a closing pixel queues the frame result.
  function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [9:0] col, logic fe);
    longint unsigned w, h, cnt, sum, ratio, q;
    blob_result_t res;
    // Red and blue plus the margin are 9-bit sums, so a large margin cannot wrap.
    if (g > floor_reg && {1'b0, g} > {1'b0, r} + {1'b0, margin_reg} &&
        {1'b0, g} > {1'b0, b} + {1'b0, margin_reg}) begin
      if (count_acc < cdbd_pkg::TALLY_MAX) count_acc = count_acc + 1'b1;
      if ({1'b0, col_acc} + col > {1'b0, cdbd_pkg::SUM_MAX}) col_acc = cdbd_pkg::SUM_MAX;
      else col_acc = col_acc + col;
    end
    if (!fe) return;
    w = bound_dim(width_reg, MAX_COLS);
    h = bound_dim(height_reg, MAX_ROWS);
    cnt = count_acc;
    sum = col_acc;
    ratio = (cnt * cdbd_pkg::ONE_Q16) / (w * h);
    if (ratio > cdbd_pkg::ONE_Q16) ratio = cdbd_pkg::ONE_Q16;
    res.green_pixels = count_acc;
    res.ratio = 17'(ratio);
    res.detected = (ratio >= detect_thr);
    res.close_by = (ratio >= close_thr);
    res.centre = '0;
    if (cnt != 0) begin
      q = (sum * cdbd_pkg::ONE_Q16) / (cnt * w);
      if (q > 65535) q = 65535;
      // q - 32768 in two's complement is q with its top bit flipped.
      res.centre = 16'(q) ^ 16'h8000;
    end
    frame_results_due.push_back(res);
    count_acc = '0;
    col_acc = '0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------------------

  function automatic void report(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  // Offers one pixel word, sometimes after an idle burst, and holds it until it is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [9:0] col, logic fe);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_level <= r;
    in_green_level <= g;
    in_blue_level <= b;
    in_column <= col;
    in_frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    predict_pixel(r, g, b, col, fe);
  endtask

  // One register write; the write enable then drops before the task returns.
  task automatic write_reg(logic [cdbd_pkg::CFG_IDX_W-1:0] idx,
                           logic [cdbd_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  // Stops offering, waits for every due result, then lets the block settle before
  // any register is touched.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The receiver alternates ready and stalled bursts of random length while idling is on.
  // A new hold request overrides that with one long stall counted here.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else if (idle_enable && $urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      burst_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ready <= 1'b1;
      burst_left = idle_enable ? $urandom_range(1, 16) - 1 : 0;
    end
  end

  // Every accepted result word is compared field by field with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (frame_results_due.size() == 0) begin
        report($sformatf("result word with nothing due: green_pixels 0x%0h",
                         out_green_pixels));
      end else begin
        due_word = frame_results_due.pop_front();
        if (out_green_pixels !== due_word.green_pixels)
          report($sformatf("green_pixels: expected 0x%0h, got 0x%0h",
                           due_word.green_pixels, out_green_pixels));
        if (out_ratio_q16 !== due_word.ratio)
          report($sformatf("ratio_q16: expected 0x%0h, got 0x%0h",
                           due_word.ratio, out_ratio_q16));
        if (out_detected !== due_word.detected)
          report($sformatf("detected: expected %0b, got %0b",
                           due_word.detected, out_detected));
        if (out_close_by !== due_word.close_by)
          report($sformatf("close_by: expected %0b, got %0b",
                           due_word.close_by, out_close_by));
        if (out_center_q15 !== due_word.centre)
          report($sformatf("center_q15: expected 0x%0h, got 0x%0h",
                           due_word.centre, out_center_q15));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Random settings and pixels
  // ---------------------------------------------------------------------------------------

  // Sometimes fills the data bits above the register's width with noise.
  function automatic logic [cdbd_pkg::CFG_DATA_W-1:0] with_noise(
      logic [cdbd_pkg::CFG_DATA_W-1:0] v, int bits);
    logic [cdbd_pkg::CFG_DATA_W-1:0] keep;
    keep = (17'h1 << bits) - 17'h1;
    if ($urandom_range(0, 3) == 0) return (17'($urandom) & ~keep) | v;
    return v;
  endfunction

  // Mostly small frames so ratios spread out; now and then zero or past the maximum.
  function automatic logic [cdbd_pkg::CFG_DATA_W-1:0] pick_dimension(int typical);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'($urandom_range(MAX_COLS + 1, 2047));
      2: return 17'(MAX_COLS);
      default: return 17'($urandom_range(1, typical));
    endcase
  endfunction

  function automatic logic [cdbd_pkg::CFG_DATA_W-1:0] pick_level(int typical);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'd255;
      default: return 17'($urandom_range(0, typical));
    endcase
  endfunction

  // Thresholds include zero, exactly one, and values no ratio can reach.
  function automatic logic [cdbd_pkg::CFG_DATA_W-1:0] pick_threshold(int typical);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'(cdbd_pkg::ONE_Q16);
      2: return 17'($urandom);
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, typical));
    endcase
  endfunction

  task automatic program_random_settings();
    write_reg(cdbd_pkg::REG_FRAME_WIDTH, with_noise(pick_dimension(16), 11));
    write_reg(cdbd_pkg::REG_FRAME_HEIGHT, with_noise(pick_dimension(8), 11));
    write_reg(cdbd_pkg::REG_GREEN_FLOOR, with_noise(pick_level(180), 8));
    write_reg(cdbd_pkg::REG_MARGIN, with_noise(pick_level(90), 8));
    write_reg(cdbd_pkg::REG_DETECT_RATIO, pick_threshold(20000));
    write_reg(cdbd_pkg::REG_CLOSE_RATIO, pick_threshold(65536));
  endtask

  // Most pixels are built to be green-dominant under the current floor and margin, some
  // sit exactly on the margin, the rest are plain noise. Columns mostly fall inside
  // the frame width.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int lo, top, span;
    span = int'(bound_dim(width_reg, MAX_COLS));
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.column = 10'($urandom);
    p.frame_end = 1'b0;
    lo = int'(floor_reg > margin_reg ? floor_reg : margin_reg) + 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: if (lo <= 255) begin
        p.green = 8'($urandom_range(lo, 255));
        top = int'(p.green) - int'(margin_reg) - 1;
        p.red = 8'($urandom_range(0, top));
        p.blue = 8'($urandom_range(0, top));
      end
      6: if (lo <= 255) begin
        // Red equal to green minus the margin falls just short of dominance.
        p.green = 8'($urandom_range(lo, 255));
        top = int'(p.green) - int'(margin_reg);
        p.red = 8'(top);
        p.blue = 8'($urandom_range(0, top));
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) < 7) p.column = 10'($urandom_range(0, span - 1));
    return p;
  endfunction

  // A frame of random length, no longer than a little over the frame's area, closed by
  // a frame_end pixel.
  task automatic send_random_frame(inout int sent);
    pixel_t p;
    longint unsigned area;
    int len;
    area = bound_dim(width_reg, MAX_COLS) * bound_dim(height_reg, MAX_ROWS);
    len = (area > 44) ? 48 : int'(area) + 4;
    len = $urandom_range(1, len);
    for (int i = 0; i < len; i++) begin
      p = random_pixel();
      send_pixel(p.red, p.green, p.blue, p.column, i == len - 1);
    end
    sent += len;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset values: width and height 64, floor 100, margin 30. Pixels on each side of the
  // floor and of the margin, a fully saturated white pixel whose red plus margin would
  // wrap in eight bits, and a frame with no green at all.
  task automatic test_default_settings();
    send_pixel(8'd70, 8'd101, 8'd70, 10'd0, 1'b0);
    send_pixel(8'd0, 8'd100, 8'd0, 10'd1, 1'b0);
    send_pixel(8'd100, 8'd131, 8'd0, 10'd2, 1'b0);
    send_pixel(8'd0, 8'd130, 8'd100, 10'd3, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 1'b1);
  endtask

  task automatic test_limits();
    wait_until_idle();
    // Zero dimensions count as one pixel; floor and margin at zero; detect exactly at
    // one, close out of reach.
    write_reg(cdbd_pkg::REG_FRAME_WIDTH, 17'd0);
    write_reg(cdbd_pkg::REG_FRAME_HEIGHT, 17'd0);
    write_reg(cdbd_pkg::REG_GREEN_FLOOR, 17'd0);
    write_reg(cdbd_pkg::REG_MARGIN, 17'd0);
    write_reg(cdbd_pkg::REG_DETECT_RATIO, 17'(cdbd_pkg::ONE_Q16));
    write_reg(cdbd_pkg::REG_CLOSE_RATIO, 17'h1FFFF);
    // Two green pixels over a one-pixel frame saturate the ratio, and columns past the
    // width pin the centre at its top.
    send_pixel(8'd0, 8'd1, 8'd0, 10'd5, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd1023, 1'b1);
    // A single green pixel in column zero puts the centre at its bottom.
    send_pixel(8'd0, 8'd1, 8'd0, 10'd0, 1'b1);
    wait_until_idle();
    // Floor and margin at their top: nothing can count as green.
    write_reg(cdbd_pkg::REG_GREEN_FLOOR, 17'd255);
    write_reg(cdbd_pkg::REG_MARGIN, 17'd255);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd10, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 10'd20, 1'b1);
    wait_until_idle();
    // Dimensions past the maximum with noise in the unused data bits, thresholds at zero.
    write_reg(cdbd_pkg::REG_FRAME_WIDTH, 17'h1_07FF);
    write_reg(cdbd_pkg::REG_FRAME_HEIGHT, 17'h1_FFFF);
    write_reg(cdbd_pkg::REG_GREEN_FLOOR, 17'h1_FF64);
    write_reg(cdbd_pkg::REG_MARGIN, 17'h0_FF1E);
    write_reg(cdbd_pkg::REG_DETECT_RATIO, 17'd0);
    write_reg(cdbd_pkg::REG_CLOSE_RATIO, 17'd0);
    send_pixel(8'd50, 8'd200, 8'd50, 10'd1023, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 1'b1);
  endtask

  // Writes to indexes with no register behind them must leave every setting as it was.
  task automatic test_spare_indexes();
    wait_until_idle();
    write_reg(REG_SPARE_6, 17'd1);
    write_reg(REG_SPARE_7, 17'h1FFFF);
    send_pixel(8'd10, 8'd150, 8'd10, 10'd512, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 10'd3, 1'b1);
  endtask

  task automatic test_random_frames(int phases, int words_per_phase);
    int sent;
    repeat (phases) begin
      wait_until_idle();
      program_random_settings();
      sent = 0;
      while (sent < words_per_phase) send_random_frame(sent);
    end
  endtask

  // The receiver stalls for a long stretch just as a frame closes, while the sender keeps
  // offering pixels back to back; the pending result must block the pixel input.
  task automatic test_output_hold();
    int sent;
    wait_until_idle();
    program_random_settings();
    idle_enable = 1'b0;
    hold_requests++;
    sent = 0;
    send_pixel(8'd0, 8'd255, 8'd0, 10'd1, 1'b1);
    while (sent < 40) send_random_frame(sent);
    idle_enable = 1'b1;
  endtask

  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_settings();
    test_limits();
    test_spare_indexes();
    test_random_frames(10, 135);
    test_output_hold();
    // The last stretch runs at full rate on both sides.
    idle_enable = 1'b0;
    test_random_frames(2, 180);
    wait_until_idle();
    if (frame_results_due.size() != 0)
      report($sformatf("%0d frame results never arrived", frame_results_due.size()));
    $display("Sent %0d pixel words and checked %0d frame results after %0d register writes,",
             pixels_sent, results_checked, reg_writes);
    $display("covering clamped and saturated cases, spare indexes and a %0d-cycle output hold.",
             LONG_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/cdbd_pkg.sv
hdl/cdbd_ctrl.sv
hdl/cdbd_datapath.sv
hdl/color_dominance_blob_detector.sv
verif/tb_color_dominance_blob_detector.sv
